// ===== src/pdc_pkg.sv =====
// Package for the PPPoE session decapsulator: item types, header constants,
// control state encoding and the cell control struct. No dependencies.
`timescale 1ns / 1ps

package pdc_pkg;

  // Header geometry
  localparam int HdrLen   = 22;
  localparam int MacLen   = 12;
  localparam int StripLen = MacLen + 2;
  localparam int PosW     = $clog2(HdrLen + 1);

  // Field values
  localparam logic [15:0] EtypePppoeSess = 16'h8864;
  localparam logic [15:0] PppProtoIpv4   = 16'h0021;
  localparam logic [15:0] PppProtoIpv6   = 16'h0057;
  localparam logic [15:0] EtypeIpv4      = 16'h0800;
  localparam logic [15:0] EtypeIpv6      = 16'h86DD;
  localparam logic [15:0] SessionAny     = 16'h0000;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_stripped;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_FLUSH,
    ST_PASS
  } state_t;

  // Per-cell control: shift moves the neighbour's byte in, load takes new data
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== src/pdc_cell.sv =====
// One header cell of the decapsulator chain: holds a byte, loads it from the
// stream and hands it to its lower neighbour while the header drains. Uses pdc_pkg.
`timescale 1ns / 1ps

module pdc_cell
  import pdc_pkg::*;
(
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic [7:0] load_data,
  input  logic [7:0] nbr_data,
  output logic [7:0] data
);

  // Shift takes priority; load captures a header byte
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= nbr_data;
    end else if (ctl.load) begin
      data <= load_data;
    end
  end

endmodule

// ===== src/pppoe_session_decap.sv =====
// Top level of the PPPoE session decapsulator: control sequencer, header judge,
// the chain of pdc_cell header cells and the output register. Uses pdc_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   in_valid/in_stall/in_item carry one frame byte per item (in_byte, in_last).
//   out_valid/out_stall/out_item deliver output bytes (out_byte, out_last,
//   out_stripped). An item moves on an edge with valid high and stall low.
//   match_session_we writes match_session (0 accepts any session); write it
//   only while the block is idle.
// Timing:
//   The first 22 bytes of a frame are taken one per cycle into a row of 22
//   cells and produce nothing. When the 22nd byte (or an earlier last byte)
//   arrives, the row drains from cell 0, one byte per cycle while the output
//   is not stalled: 14 bytes for a stripped header, 22 for an unchanged one,
//   the held count for a short frame. in_stall is high during that drain.
//   Later bytes pass through the output register, one per unstalled cycle.
// Reset (rst, synchronous): empties the output register, clears the header
//   count and the stored session ID; the next byte starts a new frame.
// Stall: a stalled output item is held; the drain pauses and in_stall rises
//   for payload bytes until the output register frees.
//
module pppoe_session_decap
  import pdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       match_session_we,
  input  logic [15:0] match_session,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  state_t          state, state_next;
  logic [PosW-1:0] pos, pos_next;
  logic [PosW-1:0] count, count_next;
  logic            flush_last, flush_last_next;
  logic            strip_flag, strip_flag_next;
  logic [15:0]     session_reg;
  logic            out_valid_next;
  out_item_t       out_item_next;

  logic [7:0]      cell_q [HdrLen];
  logic            in_acc;
  logic            out_free;
  logic            col_acc;
  logic            decide;
  logic            drain;
  logic            v4, v6, ok;
  logic [15:0]     etype, sess, proto, l3;

  // Handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state == ST_FLUSH) || ((state == ST_PASS) && !out_free);
  assign in_acc   = in_valid && !in_stall;
  assign col_acc  = in_acc && (state == ST_COLLECT);
  assign decide   = col_acc && (pos == PosW'(HdrLen - 1));
  assign drain    = (state == ST_FLUSH) && out_free;

  // Judge the header as its final byte arrives
  assign etype = {cell_q[12], cell_q[13]};
  assign sess  = {cell_q[16], cell_q[17]};
  assign proto = {cell_q[20], in_item.in_byte};
  assign v4    = (proto == PppProtoIpv4);
  assign v6    = (proto == PppProtoIpv6);
  assign ok    = (etype == EtypePppoeSess) && (v4 || v6) &&
                 ((session_reg == SessionAny) || (sess == session_reg));
  assign l3    = v6 ? EtypeIpv6 : EtypeIpv4;

  // Hold the configured session ID
  always_ff @(posedge clk) begin
    if (rst) begin
      session_reg <= '0;
    end else if (match_session_we) begin
      session_reg <= match_session;
    end
  end

  // Row of header cells
  for (genvar k = 0; k < HdrLen; k++) begin : g_cell
    cell_ctl_t  ctl;
    logic [7:0] ld;
    logic [7:0] nbr;

    if (k == MacLen || k == MacLen + 1) begin : g_etype
      assign ld = (decide && ok) ? ((k == MacLen) ? l3[15:8] : l3[7:0]) : in_item.in_byte;
      assign ctl.load = (col_acc && (pos == PosW'(k))) || (decide && ok);
    end else begin : g_plain
      assign ld = in_item.in_byte;
      assign ctl.load = col_acc && (pos == PosW'(k));
    end
    assign ctl.shift = drain;

    if (k == HdrLen - 1) begin : g_end
      assign nbr = 8'h00;
    end else begin : g_mid
      assign nbr = cell_q[k + 1];
    end

    pdc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_data (ld),
      .nbr_data  (nbr),
      .data      (cell_q[k])
    );
  end

  // State register and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_COLLECT;
      pos        <= '0;
      count      <= '0;
      flush_last <= 1'b0;
      strip_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pos        <= pos_next;
      count      <= count_next;
      flush_last <= flush_last_next;
      strip_flag <= strip_flag_next;
      out_valid  <= out_valid_next;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    out_item <= out_item_next;
  end

  // Next state and outputs
  always_comb begin
    state_next      = state;
    pos_next        = pos;
    count_next      = count;
    flush_last_next = flush_last;
    strip_flag_next = strip_flag;
    out_valid_next  = out_valid && out_stall;
    out_item_next   = out_item;
    case (state)
      ST_COLLECT: begin
        if (col_acc) begin
          pos_next = pos + PosW'(1);
          if (decide) begin
            state_next      = ST_FLUSH;
            count_next      = ok ? PosW'(StripLen) : PosW'(HdrLen);
            flush_last_next = in_item.in_last;
            strip_flag_next = ok;
          end else if (in_item.in_last) begin
            state_next      = ST_FLUSH;
            count_next      = pos + PosW'(1);
            flush_last_next = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (drain) begin
          out_valid_next         = 1'b1;
          out_item_next.out_byte = cell_q[0];
          out_item_next.out_last = flush_last && (count == PosW'(1));
          out_item_next.out_stripped = strip_flag;
          count_next = count - PosW'(1);
          if (count == PosW'(1)) begin
            pos_next = '0;
            if (flush_last) begin
              state_next      = ST_COLLECT;
              strip_flag_next = 1'b0;
            end else begin
              state_next = ST_PASS;
            end
          end
        end
      end
      ST_PASS: begin
        if (in_acc) begin
          out_valid_next             = 1'b1;
          out_item_next.out_byte     = in_item.in_byte;
          out_item_next.out_last     = in_item.in_last;
          out_item_next.out_stripped = strip_flag;
          if (in_item.in_last) begin
            state_next      = ST_COLLECT;
            strip_flag_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // A drain always has bytes left to emit
  a_flush_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (count != '0))
    else $error("drain with empty count");

  // A last byte while collecting starts a drain
  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    (col_acc && in_item.in_last) |=> (state == ST_FLUSH))
    else $error("last header byte did not start a drain");

  // No strip mark survives into a new frame
  a_strip_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COLLECT) |-> !strip_flag)
    else $error("strip flag set while collecting");

  // A stripped header drains 14 bytes
  a_strip_len: assert property (@(posedge clk) disable iff (rst)
    (decide && ok) |=> (count == PosW'(StripLen)))
    else $error("stripped header length wrong");
`endif

endmodule

// ===== verif/tb_pppoe_session_decap.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pppoe_session_decap: sends whole frames byte by byte,
// predicts the stripped or passed-through output stream and checks each output item.
// Depends on pdc_pkg and the pppoe_session_decap RTL.

module tb_pppoe_session_decap;
  import pdc_pkg::*;

  // Byte offsets inside the Ethernet + PPPoE + PPP header
  localparam int OffEtype   = 12;
  localparam int OffSession = 16;
  localparam int OffProto   = 20;
  localparam int DrainLimit = 20000;
  localparam int TailCycles = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        match_session_we = 1'b0;
  logic [15:0] match_session = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;

  pppoe_session_decap DUT (
    .clk              (clk),
    .rst              (rst),
    .match_session_we (match_session_we),
    .match_session    (match_session),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item         (out_item)
  );

  always #5 clk = ~clk;

  // Predictor state: header copy, judgement of the current frame, session filter
  logic [7:0]  hdr_copy [HdrLen];
  int          hdr_count = 0;
  logic        hdr_judged = 1'b0;
  logic        frame_stripped = 1'b0;
  logic [15:0] session_sel = SessionAny;
  out_item_t   expected_bytes [$];
  int          err_count = 0;

  // Stimulus control
  logic [7:0]  frame_q [$];
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  int          rx_hold_req = 0;
  int          rx_stall_left = 0;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic push_result(input logic [7:0] b, input logic l, input logic s);
    out_item_t r;
    r.out_byte     = b;
    r.out_last     = l;
    r.out_stripped = s;
    expected_bytes.push_back(r);
  endtask

  // Work out the output items caused by one accepted input byte
  task automatic predict_decap(input in_item_t it);
    logic [15:0] etype;
    logic [15:0] sess;
    logic [15:0] proto;
    logic [15:0] l3;
    logic        ok;
    if (hdr_judged) begin
      push_result(it.in_byte, it.in_last, frame_stripped);
      if (it.in_last) begin
        hdr_judged     = 1'b0;
        frame_stripped = 1'b0;
      end
    end else begin
      hdr_copy[hdr_count] = it.in_byte;
      hdr_count++;
      if (hdr_count < HdrLen) begin
        // Short frame: flush what is held, unchanged
        if (it.in_last) begin
          for (int i = 0; i < hdr_count; i++)
            push_result(hdr_copy[i], i == hdr_count - 1, 1'b0);
          hdr_count = 0;
        end
      end else begin
        etype = {hdr_copy[OffEtype], hdr_copy[OffEtype + 1]};
        sess  = {hdr_copy[OffSession], hdr_copy[OffSession + 1]};
        proto = {hdr_copy[OffProto], hdr_copy[OffProto + 1]};
        ok = etype == EtypePppoeSess
             && (proto == PppProtoIpv4 || proto == PppProtoIpv6)
             && (session_sel == SessionAny || sess == session_sel);
        if (ok) begin
          l3 = (proto == PppProtoIpv6) ? EtypeIpv6 : EtypeIpv4;
          for (int i = 0; i < MacLen; i++) push_result(hdr_copy[i], 1'b0, 1'b1);
          push_result(l3[15:8], 1'b0, 1'b1);
          push_result(l3[7:0], it.in_last, 1'b1);
        end else begin
          for (int i = 0; i < HdrLen; i++)
            push_result(hdr_copy[i], it.in_last && i == HdrLen - 1, 1'b0);
        end
        hdr_count      = 0;
        hdr_judged     = !it.in_last;
        frame_stripped = ok && !it.in_last;
      end
    end
  endtask

  // Predict on every accepted input item
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) predict_decap(in_item);
  end

  // Compare every accepted output item with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output item: byte %02h last %0b stripped %0b",
               out_item.out_byte, out_item.out_last, out_item.out_stripped);
        err_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_item.out_byte);
          err_count++;
        end
        if (out_item.out_last !== want.out_last) begin
          $error("out_last: expected %0b, got %0b", want.out_last, out_item.out_last);
          err_count++;
        end
        if (out_item.out_stripped !== want.out_stripped) begin
          $error("out_stripped: expected %0b, got %0b",
                 want.out_stripped, out_item.out_stripped);
          err_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_stall_left = rx_hold_req;
      rx_hold_req   = 0;
    end
    if (rx_stall_left > 0) begin
      out_stall <= 1'b1;
      rx_stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (rx_gaps && $urandom_range(0, 3) == 0) rx_stall_left = pick_gap();
    end
  end

  // Offer one byte, with an optional gap first, and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= {b, l};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Build a frame in frame_q; fill < 0 gives random MAC and payload bytes
  task automatic make_frame(input logic [15:0] etype, input logic [15:0] sess,
                            input logic [15:0] proto, input int len, input int fill);
    logic [7:0] b;
    frame_q.delete();
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      case (i)
        OffEtype:       b = etype[15:8];
        OffEtype + 1:   b = etype[7:0];
        OffSession:     b = sess[15:8];
        OffSession + 1: b = sess[7:0];
        OffProto:       b = proto[15:8];
        OffProto + 1:   b = proto[7:0];
        default: ;
      endcase
      frame_q.push_back(b);
    end
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic send_new_frame(input logic [15:0] etype, input logic [15:0] sess,
                                input logic [15:0] proto, input int len, input int fill);
    make_frame(etype, sess, proto, len, fill);
    send_frame();
  endtask

  // Drop valid, wait for every expected item, then let the block settle
  task automatic wait_idle();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (expected_bytes.size() != 0) begin
      $error("%0d expected output items never arrived", expected_bytes.size());
      err_count++;
      expected_bytes.delete();
    end
    repeat (TailCycles) @(posedge clk);
  endtask

  // Only call with the block idle
  task automatic set_session(input logic [15:0] v);
    @(negedge clk);
    match_session_we <= 1'b1;
    match_session    <= v;
    @(negedge clk);
    match_session_we <= 1'b0;
    session_sel = v;
  endtask

  function automatic int frame_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(41, 64);
    return $urandom_range(22, 34);
  endfunction

  // One random frame: mostly well-formed sessions, the rest near misses and noise
  task automatic random_frame();
    logic [15:0] sess;
    logic [15:0] proto;
    logic [15:0] etype;
    int          r;
    r     = $urandom_range(0, 99);
    sess  = (session_sel == SessionAny) ? 16'($urandom) : session_sel;
    proto = $urandom_range(0, 1) ? PppProtoIpv6 : PppProtoIpv4;
    etype = EtypePppoeSess;
    if (r < 55) begin
      make_frame(etype, sess, proto, frame_len(), -1);
    end else if (r < 65) begin
      make_frame(etype, session_sel ^ 16'($urandom_range(1, 65535)), proto, frame_len(), -1);
    end else if (r < 75) begin
      case ($urandom_range(0, 4))
        0: proto = 16'h0020;
        1: proto = 16'h0022;
        2: proto = 16'h0056;
        3: proto = 16'h0058;
        default: proto = 16'($urandom);
      endcase
      make_frame(etype, sess, proto, frame_len(), -1);
    end else if (r < 85) begin
      case ($urandom_range(0, 3))
        0: etype = 16'h8863;
        1: etype = 16'h8865;
        2: etype = EtypeIpv4;
        default: etype = 16'($urandom);
      endcase
      make_frame(etype, sess, proto, frame_len(), -1);
    end else begin
      make_frame(etype, sess, proto, $urandom_range(1, HdrLen - 1), -1);
    end
    send_frame();
  endtask

  // Frames that end before the header is complete
  task automatic test_short_frames();
    send_new_frame(EtypePppoeSess, 16'h0001, PppProtoIpv4, 1, 8'h00);
    send_new_frame(EtypePppoeSess, 16'h0001, PppProtoIpv4, 1, 8'hFF);
    send_new_frame(EtypePppoeSess, 16'h0001, PppProtoIpv4, HdrLen - 1, -1);
    send_new_frame(16'($urandom), 16'($urandom), 16'($urandom), 13, -1);
    wait_idle();
  endtask

  // Frames that end exactly on, or just after, the header
  task automatic test_header_boundary();
    send_new_frame(EtypePppoeSess, 16'h0000, PppProtoIpv4, HdrLen, 8'h00);
    send_new_frame(EtypeIpv4, 16'hFFFF, PppProtoIpv4, HdrLen, 8'hFF);
    send_new_frame(EtypePppoeSess, 16'hFFFF, PppProtoIpv6, HdrLen + 1, 8'hFF);
    send_new_frame(EtypePppoeSess, 16'h1234, PppProtoIpv6, HdrLen, -1);
    wait_idle();
  endtask

  // Session filter at its extremes; zero in the frame is no wildcard
  task automatic test_session_filter();
    set_session(16'hFFFF);
    send_new_frame(EtypePppoeSess, 16'hFFFF, PppProtoIpv4, HdrLen, -1);
    send_new_frame(EtypePppoeSess, 16'h0000, PppProtoIpv6, HdrLen, -1);
    wait_idle();
    set_session(16'h0001);
    send_new_frame(EtypePppoeSess, 16'h0001, PppProtoIpv6, HdrLen + 1, -1);
    send_new_frame(EtypePppoeSess, 16'h8001, PppProtoIpv4, HdrLen, -1);
    wait_idle();
  endtask

  // Near-miss protocol, with no idling on either side
  task automatic test_protocols();
    logic [15:0] sess;
    sess = 16'($urandom_range(1, 65535));
    set_session(sess);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_new_frame(EtypePppoeSess, sess, 16'h0058, 23, -1);
    send_new_frame(EtypePppoeSess, sess, PppProtoIpv4, 23, -1);
    wait_idle();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // Hold the receiver off for a long stretch while the sender keeps pushing
  task automatic test_backpressure();
    set_session(SessionAny);
    tx_gaps     = 1'b0;
    rx_hold_req = 150;
    send_new_frame(EtypePppoeSess, 16'($urandom), PppProtoIpv4, 30, -1);
    send_new_frame(EtypeIpv6, 16'($urandom), PppProtoIpv6, 24, -1);
    wait_idle();
    tx_gaps = 1'b1;
  endtask

  // Random traffic over several session settings
  task automatic test_random_traffic();
    logic [15:0] sess;
    int          phase_bytes;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: sess = SessionAny;
        2: sess = 16'hFFFF;
        default: sess = 16'($urandom_range(1, 65535));
      endcase
      set_session(sess);
      tx_gaps = (ph != 2);
      rx_gaps = (ph != 2);
      phase_bytes = 0;
      while (phase_bytes < 20) begin
        random_frame();
        phase_bytes += frame_q.size();
      end
      wait_idle();
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_short_frames();
    test_header_boundary();
    test_session_filter();
    test_protocols();
    test_backpressure();
    test_random_traffic();
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
